FILE: hdl/numeric_text_field_validator_defines.svh
// ----------------------------------------------------------------------------
// Numeric text field validator: assertion macros
// Concurrent checks on the validator's internal logic. They are compiled out
// for synthesis.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_TEXT_FIELD_VALIDATOR_DEFINES_SVH
`define NUMERIC_TEXT_FIELD_VALIDATOR_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define NTFV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("validator check failed (same cycle)");
// antecedent holds -> consequent holds in the next cycle
`define NTFV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("validator check failed (next cycle)");
`else
`define NTFV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define NTFV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/ntfv_pkg.sv
// ----------------------------------------------------------------------------
// Numeric text field validator package
// Type codes and character constants shared by the validator.
// ----------------------------------------------------------------------------
package ntfv_pkg;

    // Field type codes
    localparam logic [3:0] CMD_BOOL   = 4'd0;
    localparam logic [3:0] CMD_FLOAT  = 4'd1;
    localparam logic [3:0] CMD_DOUBLE = 4'd2;
    localparam logic [3:0] CMD_LONG   = 4'd3;
    localparam logic [3:0] CMD_U64    = 4'd4;
    localparam logic [3:0] CMD_I64    = 4'd5;
    localparam logic [3:0] CMD_U32    = 4'd6;
    localparam logic [3:0] CMD_I32    = 4'd7;
    localparam logic [3:0] CMD_U16    = 4'd8;
    localparam logic [3:0] CMD_I16    = 4'd9;
    localparam logic [3:0] CMD_U8     = 4'd10;
    localparam logic [3:0] CMD_I8     = 4'd11;
    localparam logic [3:0] CMD_ALNUM  = 4'd12;

    // Characters
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_EXP_LC = 8'h65;
    localparam logic [7:0] CH_EXP_UC = 8'h45;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    // Widths
    localparam int MAG_W  = 64;
    localparam int CNT_W  = 2;
    localparam int BITS_W = 7;

    typedef logic [MAG_W-1:0] mag_t;

endpackage

FILE: hdl/numeric_text_field_validator.sv
// ----------------------------------------------------------------------------
// Numeric text field validator
// Checks a text field, one character per request, against a requested type
// (bool, float, double, integer types, alnum) and returns one verdict per
// field with the parsed integer magnitude and sign.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle, back to back, and returns one
// result request per field when the character flagged last (or an empty-field
// marker) has passed through. A character is held in an input register, then
// the per-field state (a 64-bit times-ten accumulator and a few flags) is
// updated and, on the last character, the verdict is written to the result
// register: the last character passes the input register and then the
// result register before the result is presented. The cycle time is set by
// the accumulate-by-ten and the range compare that follows it. The input
// side keeps taking characters while a result waits, except when the held
// character would itself produce a result.
`include "numeric_text_field_validator_defines.svh"

module numeric_text_field_validator
    import ntfv_pkg::*;
#(
    parameter int LONG_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // is_last
    input  logic [7:0]  s_tuser,   // [3:0] cmd, [4] is_empty, [7:5] zero
    // verdict stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] valid_res, [64:1] magnitude, [65] negative
);

    // Parse phase; the digits code doubles as the exponent mark for floats
    typedef enum logic [2:0] {
        PH_START      = 3'd0,
        PH_SIGN       = 3'd1,
        PH_DIGITS     = 3'd2,
        PH_EXP_SIGN   = 3'd3,
        PH_EXP_DIGITS = 3'd4
    } phase_t;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [3:0] cmd_reg;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       empty_reg;

    // Field state
    phase_t           phase_reg, phase_next;
    mag_t             accum_reg, accum_next;
    logic             ovf_reg, ovf_next;
    logic             minus_reg, minus_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             digit_reg, digit_next;
    logic             point_reg, point_next;
    logic             exp_reg, exp_next;
    logic             ok_reg, ok_next;

    // Result register
    logic m_valid_reg, m_valid_next;
    logic res_valid_reg;
    mag_t res_mag_reg;
    logic res_neg_reg;

    // Per-character working values
    phase_t           ph_w;
    mag_t             acc_w;
    logic             ovf_w, minus_w, digit_w, point_w, exp_w, ok_w;
    logic [CNT_W-1:0] cnt_w;
    logic             done_w;
    logic [MAG_W+3:0] prod;
    logic             is_dig, is_spc, is_sgn, is_alpha, is_int, is_uns;
    logic [BITS_W-1:0] tbits;
    logic [MAG_W:0]    one_shl;
    mag_t              half, limit;
    logic              verdict;

    logic produces, advance, accept;

    function automatic logic [BITS_W-1:0] type_bits(input logic [3:0] t);
        logic [BITS_W-1:0] b;
        case (t)
            CMD_LONG:         b = BITS_W'(LONG_BITS);
            CMD_U64, CMD_I64: b = BITS_W'(64);
            CMD_U32, CMD_I32: b = BITS_W'(32);
            CMD_U16, CMD_I16: b = BITS_W'(16);
            default:          b = BITS_W'(8);
        endcase
        return b;
    endfunction

    // Handshake
    assign produces = last_reg | empty_reg;
    assign advance  = in_valid_reg & (~produces | ~m_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_neg_reg, res_mag_reg, res_valid_reg};

    // Character classes
    assign is_dig   = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
    assign is_spc   = (ch_reg == CH_SPACE) || ((ch_reg >= CH_TAB) && (ch_reg <= CH_CR));
    assign is_sgn   = (ch_reg == CH_PLUS) || (ch_reg == CH_MINUS);
    assign is_alpha = ((ch_reg >= CH_UC_A) && (ch_reg <= CH_UC_Z))
                    || ((ch_reg >= CH_LC_A) && (ch_reg <= CH_LC_Z));
    assign is_int   = cmd_reg inside {[CMD_LONG:CMD_I8]};
    assign is_uns   = cmd_reg inside {CMD_U64, CMD_U32, CMD_U16, CMD_U8};

    // Times ten plus digit; the top bits flag overflow
    assign prod = ({4'd0, accum_reg} << 3) + ({4'd0, accum_reg} << 1)
                + {{(MAG_W+4-4){1'b0}}, ch_reg[3:0]};

    // Character step
    always_comb
    begin
        ph_w    = phase_reg;
        acc_w   = accum_reg;
        ovf_w   = ovf_reg;
        minus_w = minus_reg;
        digit_w = digit_reg;
        point_w = point_reg;
        exp_w   = exp_reg;
        ok_w    = ok_reg;
        done_w  = 1'b0;
        cnt_w   = (count_reg == '1) ? count_reg : count_reg + 1'b1;

        if (cmd_reg == CMD_BOOL)
        begin
            if ((ch_reg != CH_ZERO) && (ch_reg != CH_ONE))
                ok_w = 1'b0;
        end
        else if ((cmd_reg == CMD_FLOAT) || (cmd_reg == CMD_DOUBLE))
        begin
            if (phase_reg == PH_START)
            begin
                ph_w   = PH_SIGN;
                done_w = is_sgn;
            end
            if (!done_w)
            begin
                if (ph_w == PH_SIGN)
                begin
                    if (is_dig)
                        digit_w = 1'b1;
                    else if ((ch_reg == CH_POINT) && !point_reg)
                        point_w = 1'b1;
                    else if (((ch_reg == CH_EXP_LC) || (ch_reg == CH_EXP_UC)) && digit_reg)
                    begin
                        exp_w   = 1'b1;
                        digit_w = 1'b0;
                        ph_w    = PH_DIGITS;
                    end
                    else
                        ok_w = 1'b0;
                end
                else if ((ph_w == PH_DIGITS) && is_sgn)
                    ph_w = PH_EXP_SIGN;
                else if (is_dig)
                begin
                    digit_w = 1'b1;
                    ph_w    = PH_EXP_DIGITS;
                end
                else
                    ok_w = 1'b0;
            end
        end
        else if (is_int)
        begin
            if (phase_reg == PH_START)
            begin
                if (is_spc)
                    done_w = 1'b1;
                else if (ch_reg == CH_PLUS)
                begin
                    ph_w   = PH_SIGN;
                    done_w = 1'b1;
                end
                else if (ch_reg == CH_MINUS)
                begin
                    if (is_uns)
                        ok_w = 1'b0;
                    minus_w = 1'b1;
                    ph_w    = PH_SIGN;
                    done_w  = 1'b1;
                end
            end
            if (!done_w)
            begin
                if (is_dig)
                begin
                    ph_w    = PH_DIGITS;
                    digit_w = 1'b1;
                    if (!ovf_reg)
                    begin
                        if (|prod[MAG_W+3:MAG_W])
                        begin
                            ovf_w = 1'b1;
                            acc_w = '1;
                        end
                        else
                            acc_w = prod[MAG_W-1:0];
                    end
                end
                else
                    ok_w = 1'b0;
            end
        end
        else if (cmd_reg == CMD_ALNUM)
        begin
            if (!(is_dig || is_alpha))
                ok_w = 1'b0;
        end
        else
            ok_w = 1'b0;
    end

    // Range limit of the integer type
    assign tbits   = type_bits(cmd_reg);
    assign one_shl = (MAG_W+1)'(1) << tbits;
    assign half    = MAG_W'(1) << (tbits - 1'b1);
    assign limit   = is_uns ? MAG_W'(one_shl - (MAG_W+1)'(1))
                            : half - {{(MAG_W-1){1'b0}}, ~minus_w};

    // Verdict on the updated state
    always_comb
    begin
        verdict = 1'b0;
        if (ok_w)
        begin
            if (cmd_reg == CMD_BOOL)
                verdict = (cnt_w == CNT_W'(1));
            else if ((cmd_reg == CMD_FLOAT) || (cmd_reg == CMD_DOUBLE))
                verdict = digit_w;
            else if (is_int)
                verdict = digit_w && !ovf_w && (acc_w <= limit);
            else if (cmd_reg == CMD_ALNUM)
                verdict = (cnt_w != '0);
        end
    end

    // Next state and control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (advance && produces)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;

        phase_next = phase_reg;
        accum_next = accum_reg;
        ovf_next   = ovf_reg;
        minus_next = minus_reg;
        count_next = count_reg;
        digit_next = digit_reg;
        point_next = point_reg;
        exp_next   = exp_reg;
        ok_next    = ok_reg;
        if (advance)
        begin
            if (produces)
            begin
                phase_next = PH_START;
                accum_next = '0;
                ovf_next   = 1'b0;
                minus_next = 1'b0;
                count_next = '0;
                digit_next = 1'b0;
                point_next = 1'b0;
                exp_next   = 1'b0;
                ok_next    = 1'b1;
            end
            else
            begin
                phase_next = ph_w;
                accum_next = acc_w;
                ovf_next   = ovf_w;
                minus_next = minus_w;
                count_next = cnt_w;
                digit_next = digit_w;
                point_next = point_w;
                exp_next   = exp_w;
                ok_next    = ok_w;
            end
        end
    end

    // Control and field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_START;
            accum_reg    <= '0;
            ovf_reg      <= 1'b0;
            minus_reg    <= 1'b0;
            count_reg    <= '0;
            digit_reg    <= 1'b0;
            point_reg    <= 1'b0;
            exp_reg      <= 1'b0;
            ok_reg       <= 1'b1;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            ovf_reg      <= ovf_next;
            minus_reg    <= minus_next;
            count_reg    <= count_next;
            digit_reg    <= digit_next;
            point_reg    <= point_next;
            exp_reg      <= exp_next;
            ok_reg       <= ok_next;
        end
    end

    // Input payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= s_tuser[3:0];
            empty_reg <= s_tuser[4];
            ch_reg    <= s_tdata;
            last_reg  <= s_tlast;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && produces)
        begin
            if (empty_reg)
            begin
                res_valid_reg <= 1'b0;
                res_mag_reg   <= '0;
                res_neg_reg   <= 1'b0;
            end
            else
            begin
                res_valid_reg <= verdict;
                res_mag_reg   <= is_int ? acc_w : '0;
                res_neg_reg   <= is_int & minus_w;
            end
        end
    end

    // Checks
    `NTFV_ASSERT_NEXT(a_hold_input, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `NTFV_ASSERT_NEXT(a_result_loaded, clk, rst_n, advance && produces, m_valid_reg)
    `NTFV_ASSERT_SAME(a_ovf_saturated, clk, rst_n, ovf_reg, accum_reg == '1)
    `NTFV_ASSERT_SAME(a_fresh_field, clk, rst_n, count_reg == '0,
        phase_reg == PH_START && !digit_reg && ok_reg && !minus_reg)

endmodule
